FILE: hdl/integer_to_radix_text_macros.svh
// Assertion macros shared by the checker of the radix text converter.
`ifndef INTEGER_TO_RADIX_TEXT_MACROS_SVH
`define INTEGER_TO_RADIX_TEXT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ITRT_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ITRT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/itrt_pkg.sv
// Shared constants and the digit-to-character function of the radix text converter.
package itrt_pkg;

   localparam int VALUE_WIDTH = 64;
   localparam int DIGIT_DEPTH = 64;

   localparam int DIGIT_W = 6;
   localparam int BASE_W  = 6;
   localparam int CHAR_W  = 7;
   localparam int ADDR_W  = $clog2(DIGIT_DEPTH);
   localparam int COUNT_W = $clog2(DIGIT_DEPTH + 1);

   // Quotient bits produced per cycle by the divider, and the padded dividend width.
   localparam int DIV_BITS  = 4;
   localparam int DIV_W     = ((VALUE_WIDTH + DIV_BITS - 1) / DIV_BITS) * DIV_BITS;
   localparam int DIV_STEPS = DIV_W / DIV_BITS;
   localparam int STEP_W    = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

   localparam logic [BASE_W-1:0] BASE_MIN = BASE_W'(2);
   localparam logic [BASE_W-1:0] BASE_MAX = BASE_W'(36);
   localparam logic [BASE_W-1:0] DECIMAL  = BASE_W'(10);

   localparam logic [DIGIT_W-1:0] DIGIT_TEN = DIGIT_W'(4'hA);

   localparam logic [CHAR_W-1:0] CHAR_ZERO      = 7'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE      = 7'h39;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_A   = 7'h41;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_Z   = 7'h5A;
   localparam logic [CHAR_W-1:0] CHAR_ALPHA_OFF = CHAR_UPPER_A - CHAR_W'(4'hA);
   localparam logic [CHAR_W-1:0] CHAR_MINUS     = 7'h2D;

   function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
      if (d < DIGIT_TEN) begin
         return CHAR_ZERO + CHAR_W'(d);
      end else begin
         return CHAR_ALPHA_OFF + CHAR_W'(d);
      end
   endfunction

endpackage

FILE: hdl/itrt_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module itrt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/integer_to_radix_text.sv
// Top level of the integer to radix text converter.
//
// Usage: one request beat carries a value, a base, a minus flag and a mode.
// Mode 0 writes the value unsigned in base 2 to 36, with a leading '-' when
// the minus flag is set; mode 1 writes it as signed decimal. Each response
// beat carries two characters, most significant first, with second_valid
// clear when only one is present and last set on the final beat. A base
// outside 2 to 36 in mode 0 gives a single beat with bad_base and last set.
// Digits are produced least significant first by a shared divider that
// retires four quotient bits per cycle; they are kept in a 64-entry digit
// RAM and read back in reverse order, each character through an S_FETCH
// and an S_TAKE state. One conversion is in flight at a time: req_stall
// stays high from acceptance until the last response beat has been loaded.
// A stalled response holds its beat and the converter waits for it to drain.
// Reset returns the block to idle with no response pending; the RAM is not
// cleared.
module integer_to_radix_text (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_value,
   input  logic [5:0]  req_base,
   input  logic        req_minus_sign,
   input  logic        req_mode,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [6:0]  rsp_first_char,
   output logic [6:0]  rsp_second_char,
   output logic        rsp_second_valid,
   output logic        rsp_last,
   output logic        rsp_bad_base
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_BAD   = 3'd1;
   localparam logic [2:0] S_DIV   = 3'd2;
   localparam logic [2:0] S_FETCH = 3'd3;
   localparam logic [2:0] S_TAKE  = 3'd4;

   localparam logic [itrt_pkg::STEP_W-1:0] STEP_LAST =
      itrt_pkg::STEP_W'(itrt_pkg::DIV_STEPS - 1);
   localparam logic [itrt_pkg::COUNT_W-1:0] COUNT_FULL =
      itrt_pkg::COUNT_W'(itrt_pkg::DIGIT_DEPTH);

   logic [2:0]                       state_ff, state_in;
   logic [itrt_pkg::DIV_W-1:0]       work_ff, work_in;
   logic [itrt_pkg::DIGIT_W-1:0]     rem_ff, rem_in;
   logic [itrt_pkg::STEP_W-1:0]      step_ff, step_in;
   logic [itrt_pkg::BASE_W-1:0]      base_ff, base_in;
   logic [itrt_pkg::COUNT_W-1:0]     count_ff, count_in;
   logic [itrt_pkg::COUNT_W-1:0]     left_ff, left_in;
   logic                             neg_ff, neg_in;
   logic [itrt_pkg::CHAR_W-1:0]      hold_ff, hold_in;
   logic                             hold_valid_ff, hold_valid_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [itrt_pkg::CHAR_W-1:0]      first_ff, first_in;
   logic [itrt_pkg::CHAR_W-1:0]      second_ff, second_in;
   logic                             second_valid_ff, second_valid_in;
   logic                             last_ff, last_in;
   logic                             bad_ff, bad_in;

   logic                             req_accept;
   logic                             rsp_free;
   logic [itrt_pkg::VALUE_WIDTH-1:0] in_value;
   logic [itrt_pkg::VALUE_WIDTH-1:0] in_negated;
   logic [itrt_pkg::VALUE_WIDTH-1:0] in_mag;
   logic                             in_is_neg;
   logic                             in_base_bad;

   logic [itrt_pkg::DIV_W-1:0]       div_quo;
   logic [itrt_pkg::DIGIT_W-1:0]     div_rem;

   logic                             ram_we;
   logic                             ram_re;
   logic [itrt_pkg::COUNT_W-1:0]     left_m1;
   logic [itrt_pkg::COUNT_W-1:0]     count_next;
   logic [itrt_pkg::DIGIT_W-1:0]     ram_rdata;
   logic [itrt_pkg::CHAR_W-1:0]      take_char;

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;

   assign in_value    = req_value[itrt_pkg::VALUE_WIDTH-1:0];
   assign in_negated  = ~in_value + itrt_pkg::VALUE_WIDTH'(1);
   assign in_is_neg   = in_value[itrt_pkg::VALUE_WIDTH-1];
   assign in_mag      = (req_mode && in_is_neg) ? in_negated : in_value;
   assign in_base_bad = !req_mode &&
                        ((req_base < itrt_pkg::BASE_MIN) || (req_base > itrt_pkg::BASE_MAX));

   // Restoring division over the top quotient bits of the working value.
   always_comb begin
      logic [itrt_pkg::DIGIT_W:0]   t;
      logic [itrt_pkg::DIGIT_W-1:0] r;
      logic [itrt_pkg::DIV_W-1:0]   w;
      r = rem_ff;
      w = work_ff;
      for (int j = 0; j < itrt_pkg::DIV_BITS; j++) begin
         t = {r, w[itrt_pkg::DIV_W-1]};
         w = {w[itrt_pkg::DIV_W-2:0], 1'b0};
         if (t >= {1'b0, base_ff}) begin
            t    = t - {1'b0, base_ff};
            w[0] = 1'b1;
         end
         r = t[itrt_pkg::DIGIT_W-1:0];
      end
      div_quo = w;
      div_rem = r;
   end

   assign left_m1    = left_ff - itrt_pkg::COUNT_W'(1);
   assign ram_we     = (state_ff == S_DIV) && (step_ff == STEP_LAST) && (count_ff < COUNT_FULL);
   assign count_next = ram_we ? count_ff + itrt_pkg::COUNT_W'(1) : count_ff;
   assign take_char  = itrt_pkg::digit_char(ram_rdata);

   itrt_ram #(
      .WIDTH(itrt_pkg::DIGIT_W),
      .DEPTH(itrt_pkg::DIGIT_DEPTH)
   ) u_digit_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (count_ff[itrt_pkg::ADDR_W-1:0]),
      .wr_data (div_rem),
      .rd_en   (ram_re),
      .rd_addr (left_m1[itrt_pkg::ADDR_W-1:0]),
      .rd_data (ram_rdata)
   );

   always_comb begin
      state_in        = state_ff;
      work_in         = work_ff;
      rem_in          = rem_ff;
      step_in         = step_ff;
      base_in         = base_ff;
      count_in        = count_ff;
      left_in         = left_ff;
      neg_in          = neg_ff;
      hold_in         = hold_ff;
      hold_valid_in   = hold_valid_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      first_in        = first_ff;
      second_in       = second_ff;
      second_valid_in = second_valid_ff;
      last_in         = last_ff;
      bad_in          = bad_ff;
      ram_re          = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               work_in       = itrt_pkg::DIV_W'(in_mag);
               rem_in        = '0;
               step_in       = '0;
               count_in      = '0;
               hold_valid_in = 1'b0;
               base_in       = req_mode ? itrt_pkg::DECIMAL : req_base;
               if (in_base_bad) begin
                  state_in = S_BAD;
               end else begin
                  neg_in   = req_mode ? in_is_neg : req_minus_sign;
                  state_in = S_DIV;
               end
            end
         end
         S_BAD: begin
            if (rsp_free) begin
               rsp_valid_in    = 1'b1;
               first_in        = '0;
               second_in       = '0;
               second_valid_in = 1'b0;
               last_in         = 1'b1;
               bad_in          = 1'b1;
               state_in        = S_IDLE;
            end
         end
         S_DIV: begin
            work_in = div_quo;
            rem_in  = div_rem;
            step_in = step_ff + itrt_pkg::STEP_W'(1);
            if (step_ff == STEP_LAST) begin
               // A digit is complete: store it and start the next from a clear remainder.
               rem_in   = '0;
               step_in  = '0;
               count_in = count_next;
               if (div_quo == '0) begin
                  left_in  = count_next;
                  state_in = S_FETCH;
               end
            end
         end
         S_FETCH: begin
            // Holding off until the response register is free means a completed
            // pair can always be loaded at once.
            if (rsp_free) begin
               if (neg_ff) begin
                  hold_in       = itrt_pkg::CHAR_MINUS;
                  hold_valid_in = 1'b1;
                  neg_in        = 1'b0;
               end else if (left_ff != '0) begin
                  ram_re   = 1'b1;
                  state_in = S_TAKE;
               end else begin
                  rsp_valid_in    = 1'b1;
                  first_in        = hold_ff;
                  second_in       = '0;
                  second_valid_in = 1'b0;
                  last_in         = 1'b1;
                  bad_in          = 1'b0;
                  hold_valid_in   = 1'b0;
                  state_in        = S_IDLE;
               end
            end
         end
         S_TAKE: begin
            left_in = left_m1;
            if (!hold_valid_ff) begin
               hold_in       = take_char;
               hold_valid_in = 1'b1;
               state_in      = S_FETCH;
            end else begin
               rsp_valid_in    = 1'b1;
               first_in        = hold_ff;
               second_in       = take_char;
               second_valid_in = 1'b1;
               last_in         = (left_m1 == '0);
               bad_in          = 1'b0;
               hold_valid_in   = 1'b0;
               state_in        = (left_m1 == '0) ? S_IDLE : S_FETCH;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         work_ff       <= '0;
         count_ff      <= '0;
         neg_ff        <= 1'b0;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         work_ff       <= work_in;
         count_ff      <= count_in;
         neg_ff        <= neg_in;
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      rem_ff          <= rem_in;
      step_ff         <= step_in;
      base_ff         <= base_in;
      left_ff         <= left_in;
      hold_ff         <= hold_in;
      first_ff        <= first_in;
      second_ff       <= second_in;
      second_valid_ff <= second_valid_in;
      last_ff         <= last_in;
      bad_ff          <= bad_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_first_char   = first_ff;
   assign rsp_second_char  = second_ff;
   assign rsp_second_valid = second_valid_ff;
   assign rsp_last         = last_ff;
   assign rsp_bad_base     = bad_ff;

endmodule

FILE: hdl/itrt_checker.sv
// Port-level checker for the radix text converter, bound to the top level.
`include "integer_to_radix_text_macros.svh"

module itrt_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic [6:0]  rsp_first_char,
   input logic [6:0]  rsp_second_char,
   input logic        rsp_second_valid,
   input logic        rsp_last,
   input logic        rsp_bad_base
);

   logic req_beat;
   logic first_legal;
   logic bad_beat_bare;
   logic single_beat_bare;

   assign req_beat    = req_valid && !req_stall;
   assign first_legal = (rsp_first_char == itrt_pkg::CHAR_MINUS) ||
                        ((rsp_first_char >= itrt_pkg::CHAR_ZERO) &&
                         (rsp_first_char <= itrt_pkg::CHAR_NINE)) ||
                        ((rsp_first_char >= itrt_pkg::CHAR_UPPER_A) &&
                         (rsp_first_char <= itrt_pkg::CHAR_UPPER_Z));
   assign bad_beat_bare    = rsp_last && (rsp_first_char == '0) && !rsp_second_valid;
   assign single_beat_bare = (rsp_second_char == '0) && rsp_last;

   // An error beat is the only beat of its conversion and carries no text.
   `ITRT_ASSERT_NOW(a_bad_base_alone, rsp_valid && rsp_bad_base, bad_beat_bare, "bad_base beat is not bare")

   `ITRT_ASSERT_NOW(a_second_empty, rsp_valid && !rsp_second_valid, single_beat_bare, "short beat is wrong")

   `ITRT_ASSERT_NOW(a_first_legal, rsp_valid && !rsp_bad_base, first_legal, "first character is illegal")

   // A conversion occupies the block, so the next request must wait.
   `ITRT_ASSERT_NEXT(a_busy_after_req, req_beat, req_stall, "request taken while busy")

endmodule

bind integer_to_radix_text itrt_checker u_itrt_checker (.*);
